### design/tard_pkg.sv
`default_nettype none
package tard_pkg;
  localparam int NUM_CODES_DEF = 64;
  localparam int TRACK_ID_CODE = 57;
  localparam int MAX_OUT = 64;
  localparam logic [19:0] QUIET_MAX = 20'hFFFFF;
  localparam logic [19:0] QUIET_RESET = 20'd500;
  localparam logic [8:0] RATIO_RESET = 9'd182;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_SYNC = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_END = 2'd3;

  localparam logic [0:0] REG_QUIET = 1'b0;
  localparam logic [0:0] REG_RATIO = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic rd_sample;   // read entry at sample code
    logic wr_sample;   // merge sample into entry
    logic scan_start;  // begin a selection pass
    logic scan_step;   // look at one code
    logic take;        // mark best as taken
    logic clear;       // clear seen and taken
  } tard_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic keep;
  } tard_sts_t;
endpackage
`default_nettype wire

### design/tard_ram.sv
`default_nettype none
module tard_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/tard_datapath.sv
`default_nettype none
module tard_datapath #(
  parameter int NUM_CODES = tard_pkg::NUM_CODES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tard_pkg::tard_cmd_t          cmd,
  output tard_pkg::tard_sts_t               sts,
  input  wire logic [5:0]                   event_code,
  input  wire logic signed [31:0]           sample_value,
  input  wire logic [8:0]                   keep_ratio,
  input  wire logic                         first,
  output logic [5:0]                        best_code,
  output logic signed [31:0]                best_min,
  output logic signed [31:0]                best_max
);
  localparam int AW = $clog2(NUM_CODES);
  localparam int CW = $clog2(NUM_CODES + 1);

  logic [NUM_CODES-1:0] seen, taken;
  logic [CW-1:0] scan;
  logic          scan_rd;       // ram data valid for scan_idx
  logic [AW-1:0] scan_idx;
  logic [AW-1:0] raddr;
  logic signed [31:0] rmin, rmax;
  logic          we;
  logic signed [31:0] wmin, wmax;
  logic [AW-1:0] code_a, code_w;
  logic [5:0]    code_q;
  logic signed [31:0] value_q;
  logic          in_range;
  logic          best_ok;
  logic [31:0]   best_rng;
  logic [32:0]   limit;
  logic [31:0]   cand_rng;
  logic [40:0]   prod;

  assign code_a = AW'(event_code);
  assign code_w = AW'(code_q);
  assign raddr = cmd.scan_step ? scan[AW-1:0] : code_a;
  assign cand_rng = 32'(rmax - rmin);
  assign in_range = {3'b0, code_q} < 9'(NUM_CODES)
                    && code_q != 6'(tard_pkg::TRACK_ID_CODE);

  always_comb begin
    we = 1'b0;
    wmin = value_q;
    wmax = value_q;
    if (cmd.wr_sample && in_range) begin
      we = 1'b1;
      if (seen[code_w]) begin
        wmin = (value_q < rmin) ? value_q : rmin;
        wmax = (value_q > rmax) ? value_q : rmax;
      end
    end
  end

  tard_ram #(.WIDTH(32), .DEPTH(NUM_CODES)) u_min (
    .clk, .we, .waddr(code_w), .wdata(wmin), .raddr, .rdata(rmin));
  tard_ram #(.WIDTH(32), .DEPTH(NUM_CODES)) u_max (
    .clk, .we, .waddr(code_w), .wdata(wmax), .raddr, .rdata(rmax));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      seen <= '0;
      taken <= '0;
      scan <= '0;
      scan_rd <= 1'b0;
      best_ok <= 1'b0;
    end else begin
      // hold the sample word for the write cycle
      if (cmd.rd_sample) begin
        code_q <= event_code;
        value_q <= sample_value;
      end
      if (we) seen[code_w] <= 1'b1;
      if (cmd.scan_start) begin
        scan <= '0;
        scan_rd <= 1'b0;
        best_ok <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_rd <= scan < CW'(NUM_CODES);
        scan_idx <= scan[AW-1:0];
        if (scan < CW'(NUM_CODES)) scan <= scan + 1'b1;
        // ascending scan: >= lets a higher code win ties
        if (scan_rd && seen[scan_idx] && !taken[scan_idx]
            && (!best_ok || cand_rng >= best_rng)) begin
          best_ok <= 1'b1;
          best_rng <= cand_rng;
          best_code <= 6'(scan_idx);
          best_min <= rmin;
          best_max <= rmax;
        end
      end
      if (cmd.take) taken[AW'(best_code)] <= 1'b1;
      if (first && cmd.take) limit <= prod[40:8];
    end
  end

  assign prod = 41'(best_rng) * 41'(keep_ratio);
  assign sts.scan_done = cmd.scan_step && !scan_rd && scan == CW'(NUM_CODES);
  assign sts.found = best_ok;
  assign sts.keep = {1'b0, best_rng} >= (first ? prod[40:8] : limit);
endmodule
`default_nettype wire

### design/tard_ctrl.sv
`default_nettype none
module tard_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          action,
  input  wire logic [19:0]         quiet_ticks,
  output tard_pkg::tard_cmd_t      cmd,
  input  wire tard_pkg::tard_sts_t sts,
  output logic                     first,
  output logic                     emit_valid,
  output logic                     emit_none,
  output logic                     emit_last,
  input  wire logic                emit_free
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RMW  = 6'b000010,
    S_SCAN = 6'b000100,
    S_DEC  = 6'b001000,
    S_OUT  = 6'b010000,
    S_CLR  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic report_seen;
  logic [19:0] quiet_count, qc_inc;
  logic [6:0] n_out;
  logic acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign qc_inc = (quiet_count < tard_pkg::QUIET_MAX) ? quiet_count + 20'd1 : quiet_count;
  assign first = n_out == 7'd0;

  always_comb begin
    state_next = state;
    cmd = '0;
    emit_valid = 1'b0;
    emit_none = 1'b0;
    emit_last = 1'b0;
    unique case (state)
      S_IDLE: if (acc) begin
        unique case (action)
          tard_pkg::ACT_SAMPLE: begin
            cmd.rd_sample = 1'b1;
            state_next = S_RMW;
          end
          tard_pkg::ACT_SYNC: ;
          tard_pkg::ACT_TICK:
            if (report_seen && qc_inc > quiet_ticks) begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end
          default: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
        endcase
      end
      S_RMW: begin
        cmd.wr_sample = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_DEC;
      end
      S_DEC: begin
        if (!sts.found || !sts.keep || n_out == 7'(tard_pkg::MAX_OUT)) begin
          state_next = S_OUT;
        end else if (first || emit_free) begin
          // a held word goes out on this take, so the output must be free
          cmd.take = 1'b1;
          state_next = S_SCAN;
          cmd.scan_start = 1'b1;
        end
      end
      S_OUT: begin
        // only the last word or the none word is left to send
        if (emit_free) begin
          emit_valid = 1'b1;
          emit_none = n_out == 7'd0;
          emit_last = 1'b1;
          cmd.clear = 1'b1;
          state_next = S_CLR;
        end
      end
      S_CLR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      report_seen <= 1'b0;
      quiet_count <= '0;
      n_out <= '0;
    end else begin
      state <= state_next;
      if (cmd.clear) begin
        report_seen <= 1'b0;
        quiet_count <= '0;
      end else if (acc && action == tard_pkg::ACT_SYNC) begin
        report_seen <= 1'b1;
        quiet_count <= '0;
      end else if (acc && action == tard_pkg::ACT_TICK && report_seen) begin
        quiet_count <= qc_inc;
      end
      if (cmd.clear) n_out <= '0;
      else if (cmd.take) n_out <= n_out + 7'd1;
    end
  end
endmodule
`default_nettype wire

### design/touch_axis_range_detector.sv
// a sample word is read from the ram, then merged and written back (S_RMW);
// sync and tick words are taken in idle; no new word is taken during S_RMW.
// end of a run: each selection pass scans all NUM_CODES codes, then decides
// (S_SCAN, S_DEC); kept+1 passes, then S_OUT sends the last word and clears
// (S_CLR follows); output stalls hold the run and the input is stalled throughout.
// reset clears control state and all seen flags; min/max rams are not cleared.
`default_nettype none
module touch_axis_range_detector #(
  parameter int NUM_CODES = tard_pkg::NUM_CODES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [5:0]         event_code,
  input  wire logic signed [31:0] sample_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_code,
  output logic signed [31:0]      out_minimum,
  output logic signed [31:0]      out_maximum,
  output logic                    is_last,
  output logic                    none_found,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);
  tard_pkg::tard_cmd_t cmd;
  tard_pkg::tard_sts_t sts;
  logic [19:0] quiet_ticks;
  logic [8:0] keep_ratio;
  logic first, emit_valid, emit_none, emit_last, emit_free;
  logic [5:0] best_code;
  logic signed [31:0] best_min, best_max;

  assign cfg_ready = 1'b1;
  assign emit_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_ticks <= tard_pkg::QUIET_RESET;
      keep_ratio <= tard_pkg::RATIO_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tard_pkg::REG_QUIET: quiet_ticks <= cfg_data;
        tard_pkg::REG_RATIO: keep_ratio <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  tard_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action, .quiet_ticks, .cmd, .sts,
    .first, .emit_valid, .emit_none, .emit_last, .emit_free);

  tard_datapath #(.NUM_CODES(NUM_CODES)) u_dp (
    .clk, .rst, .cmd, .sts, .event_code, .sample_value, .keep_ratio, .first,
    .best_code, .best_min, .best_max);

  // take pushes non-final words; the final word leaves from S_OUT
  logic push, pend;
  logic [5:0] pc;
  logic signed [31:0] pmin, pmax;
  assign push = emit_valid || (cmd.take && pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (push) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.take) begin
        // hold one taken axis until it is known whether it is last
        if (pend) begin
          out_code <= pc;
          out_minimum <= pmin;
          out_maximum <= pmax;
          is_last <= 1'b0;
          none_found <= 1'b0;
        end
        pend <= 1'b1;
        pc <= best_code;
        pmin <= best_min;
        pmax <= best_max;
      end else if (emit_valid) begin
        is_last <= 1'b1;
        none_found <= emit_none;
        out_code <= emit_none ? 6'd0 : pc;
        out_minimum <= emit_none ? 32'sd0 : pmin;
        out_maximum <= emit_none ? 32'sd0 : pmax;
        pend <= 1'b0;
      end
    end
  end

  // a push while the output is stalled would lose a word
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && out_stall |-> 1'b0) else $error("output overrun");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> in_stall) else $error("input taken mid run");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_found |-> is_last) else $error("none word not last");
endmodule
`default_nettype wire
